### rtl/request_response_tag_matcher_core_defines.svh
// ---------------------------------------------------------------------------
// Request/response tag matcher: assertion macros
// Shared concurrent assertion forms for the matcher checkers.
// ---------------------------------------------------------------------------
`ifndef REQUEST_RESPONSE_TAG_MATCHER_CORE_DEFINES_SVH
`define REQUEST_RESPONSE_TAG_MATCHER_CORE_DEFINES_SVH

// same-cycle implication, off while reset is asserted
`define RRTM_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rrtm assertion failed");

// next-cycle implication, off while reset is asserted
`define RRTM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rrtm assertion failed");

`endif

### rtl/rrtm_pkg.sv
// ---------------------------------------------------------------------------
// rrtm_pkg
// Types and constants shared by the request/response tag matcher.
// ---------------------------------------------------------------------------
package rrtm_pkg;

  // field widths of one request and one result
  localparam int unsigned TAG_W        = 32;
  localparam int unsigned CONV_FIELD_W = 16;
  localparam int unsigned FRAME_W      = 32;
  localparam int unsigned TIME_W       = 64;
  localparam int unsigned OPC_W        = 8;
  localparam int unsigned OUTCOME_W    = 3;

  // packed stream widths
  localparam int unsigned IN_TDATA_W  = TAG_W + CONV_FIELD_W + FRAME_W + TIME_W + OPC_W;
  localparam int unsigned OUT_TDATA_W = FRAME_W + OPC_W + TIME_W;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } rrtm_state_e;

  // result kinds
  typedef enum logic [OUTCOME_W-1:0] {
    OUT_STORED    = 3'd0,
    OUT_REPLACED  = 3'd1,
    OUT_DROPPED   = 3'd2,
    OUT_MATCHED   = 3'd3,
    OUT_UNMATCHED = 3'd4
  } rrtm_outcome_e;

endpackage

### rtl/request_response_tag_matcher_core.sv
// ---------------------------------------------------------------------------
// request_response_tag_matcher_core
// Outstanding command table keyed by command tag and conversation.
// ---------------------------------------------------------------------------
// Usage
// - s_axis carries one PDU per request: tuser is the response flag, tdata
//   packs tag, conversation, frame number, arrival time and command byte.
// - m_axis returns exactly one result per request: tuser is the outcome
//   (stored, replaced, dropped, matched, unmatched), tdata packs the matched
//   request frame, command byte and elapsed time (zero unless matched).
// - Each request walks the slot table one slot per cycle through a single
//   read port and one tag/conversation comparator; the result is loaded into
//   the output register in the same cycle that s_axis_tready rises again,
//   and the next request is not accepted until then.
// - The table update and the 64-bit elapsed subtraction happen in the final
//   cycle, when the result is loaded into the output register.
// - If m_axis stalls, the finished result waits in the output register;
//   the next request can be accepted and scanned meanwhile, and only its
//   final cycle waits for the output register to empty.
// - Reset clears all slot valid bits at once; slot contents are not reset
//   and are only used from valid slots.
// ---------------------------------------------------------------------------
module request_response_tag_matcher_core
  import rrtm_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES     = 16,
  parameter int unsigned CONVERSATION_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // request stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [31:0] command_tag, [47:32] conversation_id, [79:48] frame_number,
  // [143:80] arrival_time_ns, [151:144] ata_opcode
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // [0] is_response
  input  logic                   s_axis_tuser,
  // result stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [31:0] matched_request_frame, [39:32] matched_opcode, [103:40] elapsed_ns
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // [2:0] outcome
  output logic [OUTCOME_W-1:0]   m_axis_tuser
);

  localparam int unsigned IDX_W     = $clog2(TABLE_ENTRIES);
  localparam int unsigned CONV_W    = CONVERSATION_BITS;
  localparam int unsigned CONV_KEEP =
    (CONVERSATION_BITS < CONV_FIELD_W) ? CONVERSATION_BITS : CONV_FIELD_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [CONV_W-1:0]  conv;
    logic [FRAME_W-1:0] frame;
    logic [TIME_W-1:0]  stamp;
    logic [OPC_W-1:0]   opcode;
  } slot_t;

  // sequencer
  rrtm_state_e state_q, state_d;
  logic [IDX_W-1:0] cnt_q;

  // latched request
  logic              resp_q;
  slot_t             item_q;

  // slot table
  logic [TABLE_ENTRIES-1:0] valid_q;
  slot_t                    mem_q [TABLE_ENTRIES];
  slot_t                    rd_q;

  // compare stage
  logic             cmp_valid_q;
  logic [IDX_W-1:0] cmp_idx_q;
  logic             match;

  // scan results
  logic               hit_q;
  logic [IDX_W-1:0]   hit_idx_q;
  logic [FRAME_W-1:0] hit_frame_q;
  logic [OPC_W-1:0]   hit_op_q;
  logic [TIME_W-1:0]  hit_time_q;
  logic               free_q;
  logic [IDX_W-1:0]   free_idx_q;

  // result register
  logic               m_valid_q;
  rrtm_outcome_e      m_outcome_q;
  logic [FRAME_W-1:0] m_frame_q;
  logic [OPC_W-1:0]   m_op_q;
  logic [TIME_W-1:0]  m_elapsed_q;

  // control
  logic               s_fire;
  logic               out_free;
  logic               finish_fire;
  logic               scan_en;

  // final decision
  rrtm_outcome_e      outcome;
  logic               wr_en;
  logic               clr_en;
  logic [IDX_W-1:0]   wr_idx;
  logic [TIME_W-1:0]  elapsed;
  slot_t              in_slot;

  // unpack an incoming request, conversation masked to the key width
  always_comb begin
    in_slot.tag    = s_axis_tdata[31:0];
    in_slot.conv   = CONV_W'(s_axis_tdata[32 +: CONV_KEEP]);
    in_slot.frame  = s_axis_tdata[79:48];
    in_slot.stamp  = s_axis_tdata[143:80];
    in_slot.opcode = s_axis_tdata[151:144];
  end

  // handshake and sequencer outputs
  always_comb begin
    s_axis_tready = (state_q == S_IDLE);
    scan_en       = (state_q == S_SCAN);
    out_free      = !m_valid_q || m_axis_tready;
    finish_fire   = (state_q == S_FINISH) && out_free;
    s_fire        = s_axis_tvalid && s_axis_tready;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_fire) state_d = S_SCAN;
      end
      S_SCAN: begin
        if (cnt_q == LAST_IDX) state_d = S_DRAIN;
      end
      S_DRAIN: begin
        state_d = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // slot counter and compare pipeline control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      cmp_valid_q <= 1'b0;
      cmp_idx_q   <= '0;
    end else begin
      cmp_valid_q <= scan_en;
      cmp_idx_q   <= cnt_q;
      if (s_fire) begin
        cnt_q <= '0;
      end else if (scan_en) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // latch the accepted request
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      resp_q <= s_axis_tuser;
      item_q <= in_slot;
    end
  end

  // slot memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_idx] <= item_q;
    if (scan_en) rd_q <= mem_q[cnt_q];
  end

  // shared key comparator
  assign match = cmp_valid_q && valid_q[cmp_idx_q] &&
                 (rd_q.tag == item_q.tag) && (rd_q.conv == item_q.conv);

  // scan bookkeeping: matching slot and lowest free slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q  <= 1'b0;
      free_q <= 1'b0;
    end else if (s_fire) begin
      hit_q  <= 1'b0;
      free_q <= 1'b0;
    end else begin
      if (match) hit_q <= 1'b1;
      if (scan_en && !free_q && !valid_q[cnt_q]) free_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (match) begin
      hit_idx_q   <= cmp_idx_q;
      hit_frame_q <= rd_q.frame;
      hit_op_q    <= rd_q.opcode;
      hit_time_q  <= rd_q.stamp;
    end
    if (scan_en && !free_q && !valid_q[cnt_q]) free_idx_q <= cnt_q;
  end

  // final decision and table update
  always_comb begin
    outcome = OUT_UNMATCHED;
    wr_en   = 1'b0;
    clr_en  = 1'b0;
    wr_idx  = hit_idx_q;
    elapsed = item_q.stamp - hit_time_q;
    if (!resp_q) begin
      if (hit_q) begin
        outcome = OUT_REPLACED;
        wr_en   = finish_fire;
      end else if (free_q) begin
        outcome = OUT_STORED;
        wr_en   = finish_fire;
        wr_idx  = free_idx_q;
      end else begin
        outcome = OUT_DROPPED;
      end
    end else if (hit_q) begin
      outcome = OUT_MATCHED;
      clr_en  = finish_fire;
    end
  end

  // slot valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (wr_en) valid_q[wr_idx] <= 1'b1;
      if (clr_en) valid_q[hit_idx_q] <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (finish_fire) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish_fire) begin
      m_outcome_q <= outcome;
      if (outcome == OUT_MATCHED) begin
        m_frame_q   <= hit_frame_q;
        m_op_q      <= hit_op_q;
        m_elapsed_q <= elapsed;
      end else begin
        m_frame_q   <= '0;
        m_op_q      <= '0;
        m_elapsed_q <= '0;
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_outcome_q;
  assign m_axis_tdata  = {m_elapsed_q, m_op_q, m_frame_q};

endmodule

### rtl/rrtm_checker.sv
// ---------------------------------------------------------------------------
// rrtm_checker
// Port-level checks on the tag matcher, bound to the top level.
// ---------------------------------------------------------------------------
`include "request_response_tag_matcher_core_defines.svh"

module rrtm_checker
  import rrtm_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [OUTCOME_W-1:0]   m_axis_tuser
);

  logic                               out_stall;
  logic                               in_fire;
  logic                               plain_result;
  logic [OUTCOME_W+OUT_TDATA_W-1:0]   out_word;

  // handshake terms
  assign out_stall    = m_axis_tvalid && !m_axis_tready;
  assign in_fire      = s_axis_tvalid && s_axis_tready;
  assign plain_result = m_axis_tvalid && (m_axis_tuser != OUT_MATCHED);
  assign out_word     = {m_axis_tuser, m_axis_tdata};

  // a stalled result holds
  `RRTM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, m_axis_tvalid && $stable(out_word))

  // only a matched response carries frame, command byte and elapsed time
  `RRTM_ASSERT_IMPLY(a_zero_payload, clk_i, rst_ni, plain_result, m_axis_tdata == '0)

  // one request at a time: the table scan follows every accepted request
  `RRTM_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_fire, !s_axis_tready)

  // the scan must run before a new result can appear
  `RRTM_ASSERT_NEXT(a_no_early_result, clk_i, rst_ni, in_fire && !m_axis_tvalid, !m_axis_tvalid)

endmodule

bind request_response_tag_matcher_core rrtm_checker u_rrtm_checker (.*);
